// ===== rtl/accel_tilt_angles_assert.svh =====
// ----------------------------------------------------------------------------
// Tilt angle assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLES_ASSERT_SVH
`define ACCEL_TILT_ANGLES_ASSERT_SVH

`ifndef SYNTH
`define ATA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tilt angle assertion failed");
`define ATA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tilt angle assertion failed");
`else
`define ATA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ATA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/ata_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt angle package
// Shared widths, angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ata_pkg;

  localparam int ANGLE_FRAC_BITS = 8;
  localparam int CORDIC_STAGES   = 16;
  localparam int INT_FRAC        = 16;

  // operand and datapath widths
  localparam int OP_W   = 30;   // CORDIC operand before the 2^8 prescale
  localparam int CW     = 42;   // CORDIC x/y
  localparam int ZW     = 27;   // internal angle, degrees * 2^16
  localparam int SQ_ROOT_W = 29;
  localparam int SQ_IN_W   = 2 * SQ_ROOT_W;
  localparam int SQ_REM_W  = SQ_ROOT_W + 4;

  localparam logic signed [ZW-1:0] D90  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] D180 = ZW'(180 * 65536);

  localparam logic [7:0] SCALE_RESET = 8'd39;
  localparam logic       REG_SCALE   = 1'b0;

  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:  v = ZW'(2949120);
      5'd1:  v = ZW'(1740967);
      5'd2:  v = ZW'(919879);
      5'd3:  v = ZW'(466945);
      5'd4:  v = ZW'(234379);
      5'd5:  v = ZW'(117304);
      5'd6:  v = ZW'(58666);
      5'd7:  v = ZW'(29335);
      5'd8:  v = ZW'(14668);
      5'd9:  v = ZW'(7334);
      5'd10: v = ZW'(3667);
      5'd11: v = ZW'(1833);
      5'd12: v = ZW'(917);
      5'd13: v = ZW'(458);
      5'd14: v = ZW'(229);
      5'd15: v = ZW'(115);
      5'd16: v = ZW'(57);
      5'd17: v = ZW'(29);
      5'd18: v = ZW'(14);
      5'd19: v = ZW'(7);
      5'd20: v = ZW'(4);
      5'd21: v = ZW'(2);
      5'd22: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/ata_isqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ata_isqrt (
  input  logic                             clk,
  input  logic                             en,
  input  logic [ata_pkg::SQ_IN_W-1:0]      rad_in,
  output logic [ata_pkg::SQ_ROOT_W-1:0]    root_out
);

  localparam int RW = ata_pkg::SQ_ROOT_W;
  localparam int NW = ata_pkg::SQ_IN_W;
  localparam int MW = ata_pkg::SQ_REM_W;

  logic [MW-1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [NW-1:0] rad_r  [RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_st
    logic [MW-1:0] rem_in, rem4, trial;
    logic [RW-1:0] root_in;
    logic [NW-1:0] rad_k;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_k   = rad_in;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_k   = rad_r[k-1];
    end

    // bring down the next two radicand bits, try 4*root+1
    assign rem4  = {rem_in[MW-3:0], rad_k[NW-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem4 >= trial) begin
          rem_r[k]  <= rem4 - trial;
          root_r[k] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem4;
          root_r[k] <= {root_in[RW-2:0], 1'b0};
        end
      end
    end

    if (k < RW - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[k] <= {rad_k[NW-3:0], 2'b00};
        end
      end
    end
  end

  assign root_out = root_r[RW-1];

endmodule

// ===== rtl/ata_cordic.sv =====
// ----------------------------------------------------------------------------
// Pipelined vectoring CORDIC
// atan2(num, den) in degrees * 2^16, one micro-rotation per stage, clamped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ata_cordic (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [ata_pkg::OP_W-1:0]     num,
  input  logic signed [ata_pkg::OP_W-1:0]     den,
  output logic signed [ata_pkg::ZW-1:0]       angle
);

  localparam int ST = ata_pkg::CORDIC_STAGES;
  localparam int CW = ata_pkg::CW;
  localparam int ZW = ata_pkg::ZW;
  localparam int OW = ata_pkg::OP_W;

  logic signed [CW-1:0] x_r [ST+1];
  logic signed [CW-1:0] y_r [ST+1];
  logic signed [ZW-1:0] z_r [ST+1];
  logic                 fix_r [ST+1];

  logic signed [CW-1:0] x0, y0;
  logic signed [ZW-1:0] z0;
  logic                 fix0;

  // prescale by 2^8, fold left half plane, catch the axis cases
  always_comb begin
    logic signed [CW-1:0] dx, ny;
    dx   = $signed({{(CW-OW-8){den[OW-1]}}, den, 8'b0});
    ny   = $signed({{(CW-OW-8){num[OW-1]}}, num, 8'b0});
    x0   = dx;
    y0   = ny;
    z0   = '0;
    fix0 = 1'b0;
    priority if (num == '0) begin
      fix0 = 1'b1;
      z0   = (den < 0) ? ata_pkg::D180 : '0;
    end else if (den == '0) begin
      fix0 = 1'b1;
      z0   = (num > 0) ? ata_pkg::D90 : -ata_pkg::D90;
    end else if (den < 0) begin
      x0 = -dx;
      y0 = -ny;
      z0 = (num > 0) ? ata_pkg::D180 : -ata_pkg::D180;
    end else begin
      // right half plane: operands go in as they are
      x0 = dx;
      y0 = ny;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= x0;
      y_r[0]   <= y0;
      z_r[0]   <= z0;
      fix_r[0] <= fix0;
    end
  end

  for (genvar i = 0; i < ST; i++) begin : g_rot
    logic signed [CW-1:0] xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        fix_r[i+1] <= fix_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= fix_r[i] ? z_r[i] : z_r[i] + ata_pkg::atan_deg(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= fix_r[i] ? z_r[i] : z_r[i] - ata_pkg::atan_deg(5'(i));
        end
      end
    end
  end

  always_comb begin
    if (z_r[ST] > ata_pkg::D180) begin
      angle = ata_pkg::D180;
    end else if (z_r[ST] < -ata_pkg::D180) begin
      angle = -ata_pkg::D180;
    end else begin
      angle = z_r[ST];
    end
  end

endmodule

// ===== rtl/accel_tilt_angles.sv =====
// ----------------------------------------------------------------------------
// Accelerometer tilt angles
// Scales a three-axis sample and gives pitch, roll and yaw by CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid with in_acc_x/y/z, taken when in_stall is low.
//   Output channel: out_valid with pitch, roll, yaw (degrees * 2^8) and the
//   scaled x value, taken when out_stall is low. One result word per input.
//   Register 0 (byte address 0): scale in tenths, reset value 39. Write it
//   only while no words are in flight.
// Timing:
//   The stages are the scale multiply, divide by ten, squares, sum,
//   29 square-root stages (one root bit each), CORDIC setup plus 16
//   rotation stages, and the output register.
//   Throughput is one word per cycle while out_stall does not hold the pipeline; every stage holds one word.
// Stall:
//   While the output word waits under out_stall the whole pipeline holds
//   and in_stall is raised; nothing is dropped or repeated.
// Reset:
//   rst_n (synchronous, active low) empties the pipeline and restores the
//   scale register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accel_tilt_angles (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_acc_x,
  input  logic signed [15:0] in_acc_y,
  input  logic signed [15:0] in_acc_z,
  // result words
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_pitch_deg,
  output logic signed [16:0] out_roll_deg,
  output logic signed [17:0] out_yaw_deg,
  output logic signed [20:0] out_scaled_x
);

  localparam int ST  = ata_pkg::CORDIC_STAGES;
  localparam int RW  = ata_pkg::SQ_ROOT_W;
  localparam int OW  = ata_pkg::OP_W;
  localparam int ZW  = ata_pkg::ZW;
  localparam int LAT = 4 + RW + ST + 2;
  localparam int RS  = ata_pkg::INT_FRAC - ata_pkg::ANGLE_FRAC_BITS;
  // x/10 as x*K >> 30, exact for |x| < 2^23
  localparam logic [26:0] DIV10_K  = 27'd107374183;
  localparam int          DIV10_SH = 30;

  function automatic logic signed [20:0] div10(input logic signed [24:0] p);
    logic [24:0] mag;
    logic [49:0] prod;
    logic [20:0] q;
    mag  = p[24] ? 25'(-p) : p;
    prod = 50'(mag[22:0]) * 50'(DIV10_K);
    q    = {1'b0, prod[DIV10_SH +: 20]};
    return p[24] ? $signed(-q) : $signed(q);
  endfunction

  function automatic logic signed [ZW:0] round_out(input logic signed [ZW:0] a);
    return (a + (ZW+1)'(1 << (RS - 1))) >>> RS;
  endfunction

  // ---------------- configuration ----------------
  logic [7:0] scale_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == ata_pkg::REG_SCALE) ? {24'b0, scale_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= ata_pkg::SCALE_RESET;
    end else if (cfg_wr && paddr[2] == ata_pkg::REG_SCALE) begin
      scale_r <= pwdata[7:0];
    end
  end

  // ---------------- flow control ----------------
  logic           adv;
  logic [LAT-1:0] v_r;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  assign out_valid = v_r[LAT-1];

  // ---------------- scale ----------------
  logic signed [24:0] px_r, py_r, pz_r;
  logic signed [20:0] sx2_r, sy2_r, sz2_r;
  logic signed [20:0] sx3_r, sy3_r, sz3_r;
  logic signed [20:0] sx4_r, sy4_r, sz4_r;
  logic [40:0]        qy_r, qz_r;
  logic [41:0]        sum_r;
  logic signed [41:0] qy_full, qz_full;

  assign qy_full = sy2_r * sy2_r;
  assign qz_full = sz2_r * sz2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r  <= in_acc_x * $signed({1'b0, scale_r});
      py_r  <= in_acc_y * $signed({1'b0, scale_r});
      pz_r  <= in_acc_z * $signed({1'b0, scale_r});
      sx2_r <= div10(px_r);
      sy2_r <= div10(py_r);
      sz2_r <= div10(pz_r);
      qy_r  <= qy_full[40:0];
      qz_r  <= qz_full[40:0];
      sx3_r <= sx2_r;
      sy3_r <= sy2_r;
      sz3_r <= sz2_r;
      sum_r <= 42'(qy_r) + 42'(qz_r);
      sx4_r <= sx3_r;
      sy4_r <= sy3_r;
      sz4_r <= sz3_r;
    end
  end

  // ---------------- magnitude of (y, z) ----------------
  logic [RW-1:0] mag;

  ata_isqrt u_isqrt (
    .clk      (clk),
    .en       (adv),
    .rad_in   ({sum_r, 16'b0}),
    .root_out (mag)
  );

  logic signed [20:0] dx_r [RW];
  logic signed [20:0] dy_r [RW];
  logic signed [20:0] dz_r [RW];

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r[0] <= sx4_r;
      dy_r[0] <= sy4_r;
      dz_r[0] <= sz4_r;
      for (int k = 1; k < RW; k++) begin
        dx_r[k] <= dx_r[k-1];
        dy_r[k] <= dy_r[k-1];
        dz_r[k] <= dz_r[k-1];
      end
    end
  end

  // ---------------- angles ----------------
  logic signed [OW-1:0] p_num, p_den, r_num, r_den, w_num, w_den;
  logic signed [ZW-1:0] pitch_a, roll_a, yaw_a;

  assign p_num = OW'($signed({dx_r[RW-1], 8'b0}));
  assign p_den = $signed({1'b0, mag});
  assign r_num = OW'(dy_r[RW-1]);
  assign r_den = OW'(dz_r[RW-1]);
  assign w_num = OW'(dz_r[RW-1]);
  assign w_den = OW'(dx_r[RW-1]);

  ata_cordic u_pitch (.clk(clk), .en(adv), .num(p_num), .den(p_den), .angle(pitch_a));
  ata_cordic u_roll  (.clk(clk), .en(adv), .num(r_num), .den(r_den), .angle(roll_a));
  ata_cordic u_yaw   (.clk(clk), .en(adv), .num(w_num), .den(w_den), .angle(yaw_a));

  logic signed [20:0] xo_r [ST+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      xo_r[0] <= dx_r[RW-1];
      for (int k = 1; k <= ST; k++) begin
        xo_r[k] <= xo_r[k-1];
      end
    end
  end

  // ---------------- output register ----------------
  logic signed [ZW:0] pitch_q, roll_q, yaw_q;

  assign pitch_q = round_out((ZW+1)'(pitch_a));
  assign roll_q  = round_out((ZW+1)'(roll_a));
  assign yaw_q   = round_out((ZW+1)'(yaw_a) - (ZW+1)'(ata_pkg::D90));

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pitch_deg <= pitch_q[15:0];
      out_roll_deg  <= roll_q[16:0];
      out_yaw_deg   <= yaw_q[17:0];
      out_scaled_x  <= xo_r[ST];
    end
  end

  // ---------------- checks ----------------
  `include "accel_tilt_angles_assert.svh"

  `ATA_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
  `ATA_ASSERT_IMP(a_pitch_rng, clk, rst_n, out_valid, out_pitch_deg <= 16'sd23040 && out_pitch_deg >= -16'sd23040)
  `ATA_ASSERT_IMP(a_roll_rng, clk, rst_n, out_valid, out_roll_deg <= 17'sd46080 && out_roll_deg >= -17'sd46080)
  `ATA_ASSERT_NXT(a_cfg_wr, clk, rst_n, cfg_wr && paddr[2] == ata_pkg::REG_SCALE, scale_r == $past(pwdata[7:0]))

endmodule
